/* rtl/core/ptdm_pkg.sv */
// Shared types and constants for the periodic task dispatch monitor.
`default_nettype none
package ptdm_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NUM_TASKS      = 2;

  localparam logic [15:0] PERIOD0_RST = 16'd1;
  localparam logic [15:0] BUDGET0_RST = 16'd200;
  localparam logic [15:0] PERIOD1_RST = 16'd5;
  localparam logic [15:0] BUDGET1_RST = 16'd500;

  // configuration register indexes
  localparam logic [7:0] CFG_T0_PERIOD = 8'd0;
  localparam logic [7:0] CFG_T0_BUDGET = 8'd1;
  localparam logic [7:0] CFG_T1_PERIOD = 8'd2;
  localparam logic [7:0] CFG_T1_BUDGET = 8'd3;

  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_DIAG     = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_REPORT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PRE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT,
    ST_REPORT,
    ST_QUERY
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic tsk;           // task under work
    logic load;          // capture input beat
    logic store_due1;    // remember whether task one is due
    logic div_start;     // start missed-period division
    logic div_add;       // add quotient - 1 to miss count
    logic emit_dispatch; // write dispatch result, record time
    logic emit_query;    // write diagnostics answer
    logic report;        // apply runtime report
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t opcode;
    logic    due;
    logic    miss;
    logic    div_done;
    logic    out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/ptdm_datapath.sv */
// Datapath: config registers, per-task state, divider and output register.
`default_nettype none
module ptdm_datapath #(
  parameter int TIME_WIDTH = ptdm_pkg::TIME_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ptdm_pkg::dp_cmd_t  cmd,
  output ptdm_pkg::dp_stat_t      stat,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         opcode,
  input  wire logic [31:0]        now_ms,
  input  wire logic [2:0]         task_sel,
  input  wire logic [31:0]        task_runtime,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    kind,
  output logic                    task_id,
  output logic                    found,
  output logic [15:0]             period_out_ms,
  output logic [15:0]             budget_out_us,
  output logic [31:0]             max_runtime,
  output logic [31:0]             miss_total,
  output logic                    last
);

  localparam int CW = $clog2(TIME_WIDTH + 1);
  localparam int QW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  logic [15:0]           period [ptdm_pkg::NUM_TASKS];
  logic [15:0]           budget [ptdm_pkg::NUM_TASKS];
  logic [TIME_WIDTH-1:0] last_disp [ptdm_pkg::NUM_TASKS];
  logic [31:0]           peak [ptdm_pkg::NUM_TASKS];
  logic [31:0]           misses [ptdm_pkg::NUM_TASKS];

  ptdm_pkg::opcode_t     op_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [2:0]            sel_q;
  logic [31:0]           rt_q;
  logic                  due1;

  logic [TIME_WIDTH-1:0] quo;
  logic [15:0]           rem;
  logic [15:0]           dsr;
  logic [CW-1:0]         cnt;

  logic [15:0]           per_eff;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [16:0]           trial;
  logic                  trial_ge;
  logic [QW-1:0]         q_ext;
  logic                  sel_ok;
  logic                  rsel;
  logic                  out_free;

  assign per_eff  = (period[cmd.tsk] == 16'd0) ? 16'd1 : period[cmd.tsk];
  assign elapsed  = now_q - last_disp[cmd.tsk];
  assign trial    = {rem, quo[TIME_WIDTH-1]};
  assign trial_ge = trial >= {1'b0, dsr};
  assign q_ext    = QW'(quo);
  assign sel_ok   = sel_q < 3'(ptdm_pkg::NUM_TASKS);
  assign rsel     = sel_q[0];
  assign out_free = !out_valid || !out_stall;

  assign stat.opcode   = op_q;
  assign stat.due      = elapsed >= TIME_WIDTH'(per_eff);
  assign stat.miss     = {1'b0, elapsed} >= (TIME_WIDTH + 1)'({per_eff, 1'b0});
  assign stat.div_done = (cnt == '0);
  assign stat.out_free = out_free;

  // input capture, divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= ptdm_pkg::opcode_t'(opcode);
      now_q <= TIME_WIDTH'(now_ms);
      sel_q <= task_sel;
      rt_q  <= task_runtime;
    end
    if (cmd.store_due1) begin
      due1 <= stat.due;
    end
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_start) begin
      quo <= elapsed;
      rem <= '0;
      dsr <= per_eff;
      cnt <= CW'(TIME_WIDTH);
    end else if (cnt != '0) begin
      rem <= trial_ge ? 16'(trial - {1'b0, dsr}) : trial[15:0];
      quo <= {quo[TIME_WIDTH-2:0], trial_ge};
      cnt <= cnt - CW'(1);
    end
  end

  // config and per-task state
  always_ff @(posedge clk) begin
    if (rst) begin
      period[0] <= ptdm_pkg::PERIOD0_RST;
      budget[0] <= ptdm_pkg::BUDGET0_RST;
      period[1] <= ptdm_pkg::PERIOD1_RST;
      budget[1] <= ptdm_pkg::BUDGET1_RST;
      for (int i = 0; i < ptdm_pkg::NUM_TASKS; i++) begin
        last_disp[i] <= '0;
        peak[i]      <= '0;
        misses[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ptdm_pkg::CFG_T0_PERIOD: period[0] <= cfg_data[15:0];
          ptdm_pkg::CFG_T0_BUDGET: budget[0] <= cfg_data[15:0];
          ptdm_pkg::CFG_T1_PERIOD: period[1] <= cfg_data[15:0];
          ptdm_pkg::CFG_T1_BUDGET: budget[1] <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.div_add) begin
        misses[cmd.tsk] <= misses[cmd.tsk] + q_ext[31:0] - 32'd1;
      end
      if (cmd.emit_dispatch) begin
        last_disp[cmd.tsk] <= now_q;
      end
      if (cmd.report && sel_ok) begin
        if (rt_q > peak[rsel]) begin
          peak[rsel] <= rt_q;
        end
        if (rt_q > {16'd0, budget[rsel]}) begin
          misses[rsel] <= misses[rsel] + 32'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_dispatch || cmd.emit_query) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit_dispatch) begin
      kind          <= ptdm_pkg::KIND_DISPATCH;
      task_id       <= cmd.tsk;
      found         <= 1'b0;
      period_out_ms <= '0;
      budget_out_us <= '0;
      max_runtime   <= '0;
      miss_total    <= '0;
      last          <= cmd.tsk || !due1;
    end else if (cmd.emit_query) begin
      kind          <= ptdm_pkg::KIND_DIAG;
      task_id       <= sel_ok ? rsel : 1'b0;
      found         <= sel_ok;
      period_out_ms <= sel_ok ? period[rsel] : '0;
      budget_out_us <= sel_ok ? budget[rsel] : '0;
      max_runtime   <= sel_ok ? peak[rsel] : '0;
      miss_total    <= sel_ok ? misses[rsel] : '0;
      last          <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_dispatch || cmd.emit_query) |-> (!out_valid || !out_stall))
    else $error("result written while output register still holds a beat");
  a_div_load: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (cnt == CW'(TIME_WIDTH)))
    else $error("divider did not load its step count");
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_dispatch && cmd.emit_query))
    else $error("dispatch and diagnostics written together");
`endif

endmodule
`default_nettype wire

/* rtl/core/ptdm_ctrl.sv */
// Controller state machine sequencing ticks, reports and queries.
`default_nettype none
module ptdm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ptdm_pkg::dp_stat_t stat,
  output ptdm_pkg::dp_cmd_t       cmd
);

  ptdm_pkg::state_t state, state_next;
  logic             cur_task, cur_task_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ptdm_pkg::ST_IDLE;
      cur_task <= 1'b0;
    end else begin
      state    <= state_next;
      cur_task <= cur_task_next;
    end
  end

  always_comb begin
    state_next    = state;
    cur_task_next = cur_task;
    cmd           = '0;
    cmd.tsk       = cur_task;
    in_stall      = 1'b1;
    unique case (state)
      ptdm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ptdm_pkg::ST_DECODE;
        end
      end
      ptdm_pkg::ST_DECODE: begin
        unique case (stat.opcode)
          ptdm_pkg::OP_TICK: begin
            cur_task_next = 1'b1;
            state_next    = ptdm_pkg::ST_PRE;
          end
          ptdm_pkg::OP_REPORT: state_next = ptdm_pkg::ST_REPORT;
          ptdm_pkg::OP_QUERY:  state_next = ptdm_pkg::ST_QUERY;
          default:             state_next = ptdm_pkg::ST_IDLE;
        endcase
      end
      ptdm_pkg::ST_PRE: begin
        // look ahead at task one so task zero's dispatch knows its last flag
        cmd.store_due1 = 1'b1;
        cur_task_next  = 1'b0;
        state_next     = ptdm_pkg::ST_CHECK;
      end
      ptdm_pkg::ST_CHECK: begin
        priority if (!stat.due) begin
          if (cur_task) begin
            state_next = ptdm_pkg::ST_IDLE;
          end else begin
            cur_task_next = 1'b1;
          end
        end else if (stat.miss) begin
          cmd.div_start = 1'b1;
          state_next    = ptdm_pkg::ST_DIV;
        end else begin
          state_next = ptdm_pkg::ST_EMIT;
        end
      end
      ptdm_pkg::ST_DIV: begin
        if (stat.div_done) begin
          cmd.div_add = 1'b1;
          state_next  = ptdm_pkg::ST_EMIT;
        end
      end
      ptdm_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_dispatch = 1'b1;
          if (cur_task) begin
            state_next = ptdm_pkg::ST_IDLE;
          end else begin
            cur_task_next = 1'b1;
            state_next    = ptdm_pkg::ST_CHECK;
          end
        end
      end
      ptdm_pkg::ST_REPORT: begin
        cmd.report = 1'b1;
        state_next = ptdm_pkg::ST_IDLE;
      end
      ptdm_pkg::ST_QUERY: begin
        if (stat.out_free) begin
          cmd.emit_query = 1'b1;
          state_next     = ptdm_pkg::ST_IDLE;
        end
      end
      default: state_next = ptdm_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ptdm_pkg::ST_DECODE))
    else $error("accepted beat not followed by decode");
  a_div_enter: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == ptdm_pkg::ST_DIV && $stable(cur_task)))
    else $error("division started without entering divide state");
  a_task1_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_dispatch && cur_task) |=> (state == ptdm_pkg::ST_IDLE))
    else $error("tick continued past task one");
`endif

endmodule
`default_nettype wire

/* rtl/core/periodic_task_dispatch_monitor.sv */
// Sequence: an accepted beat goes to DECODE; a query is answered from QUERY into the output
// register, a report is applied in REPORT, an unused opcode returns to IDLE. A tick runs PRE,
// then CHECK per task, DIV for a missed period and EMIT per dispatch. A held result beat adds
// its stall time. One item at a time; the slowest case is a tick with both tasks late, set by
// the one-bit-per-cycle restoring divider.
// Reset (rst, synchronous): config to defaults, per-task state zero, output empty, idle.
`default_nettype none
module periodic_task_dispatch_monitor #(
  parameter int TIME_WIDTH = ptdm_pkg::TIME_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] now_ms,
  input  wire logic [2:0]  task_sel,
  input  wire logic [31:0] task_runtime,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic             task_id,
  output logic             found,
  output logic [15:0]      period_out_ms,
  output logic [15:0]      budget_out_us,
  output logic [31:0]      max_runtime,
  output logic [31:0]      miss_total,
  output logic             last,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  ptdm_pkg::dp_cmd_t  cmd;
  ptdm_pkg::dp_stat_t stat;

  // config beats are taken at any time; writes land in the datapath registers
  assign cfg_ready = 1'b1;

  // sequencer: one input beat in flight, steps the two tasks in order
  ptdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // elapsed-time compare, divider, per-task counters and the output register
  ptdm_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .now_ms        (now_ms),
    .task_sel      (task_sel),
    .task_runtime  (task_runtime),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .task_id       (task_id),
    .found         (found),
    .period_out_ms (period_out_ms),
    .budget_out_us (budget_out_us),
    .max_runtime   (max_runtime),
    .miss_total    (miss_total),
    .last          (last)
  );

endmodule
`default_nettype wire
